>>> sv/pair_cooccurrence_threshold_assert.svh
// Assertion macros for the pair co-occurrence threshold block.
// Used by the top level only; expects a clock and an active-low reset name.
`ifndef PAIR_COOCCURRENCE_THRESHOLD_ASSERT_SVH
`define PAIR_COOCCURRENCE_THRESHOLD_ASSERT_SVH

// Same-cycle implication.
`define PCT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pct_pkg.sv
// Shared types and constants for the pair co-occurrence threshold block.
// No dependencies.
package pct_pkg;

    localparam int LETTER_W   = 5;
    localparam int POS_W      = 4;
    localparam int SEQ_W      = 4;
    localparam int THR_W      = 16;
    localparam int NUM_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int Q_DEPTH    = 4;

    localparam int DEF_MAX_LENGTH  = 9;
    localparam int DEF_ALPHABET    = 32;
    localparam int DEF_COUNT_WIDTH = 16;

    localparam logic [SEQ_W-1:0] RESET_SEQ_LEN   = 4'd9;
    localparam logic [THR_W-1:0] RESET_THRESHOLD = 16'd1;
    localparam logic [NUM_W-1:0] NUM_MAX         = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LEN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

    localparam logic CMD_LETTER = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                command;
        logic [LETTER_W-1:0] letter;
    } t_item;

    typedef struct packed {
        logic [LETTER_W-1:0] first_letter;
        logic [POS_W-1:0]    first_position;
        logic [LETTER_W-1:0] second_letter;
        logic [POS_W-1:0]    second_position;
        logic [NUM_W-1:0]    pair_number;
        logic                last_of_run;
    } t_result;

    // One unit of work handed from the front end to the count engine.
    typedef struct packed {
        logic                is_clear;
        logic                last;
        logic [LETTER_W-1:0] first_letter;
        logic [POS_W-1:0]    first_position;
        logic [LETTER_W-1:0] second_letter;
        logic [POS_W-1:0]    second_position;
    } t_task;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> sv/pair_cooccurrence_threshold.sv
// Pair co-occurrence threshold detector: top level, configuration registers.
// Depends on pct_pkg, pct_front, pct_fifo, pct_back and the assertion macros.
//
// Usage: drive i_item and raise start; the item is taken at a clock edge with
// start high and busy low. Letters are buffered one per cycle while busy is
// low. The letter that completes a sequence of n letters starts a walk of
// n(n-1)/2 position pairs, one count update per cycle while the task queue
// is not full, through a single read-modify-write port of the count store;
// another sequence's last letter is held off (busy) until that walk has been
// issued. A reported pair is held until the next pair of its run matches or
// the run ends; the last-of-run pair is released by the registered end-of-run
// flag and shown through the o_result register.
// Results show on o_result for one cycle with o_result_valid; the receiver
// cannot stall. A clear item waits for earlier work, then sweeps the count
// store one entry a cycle with busy high.
// Reset runs the same sweep. Registers are written through i_cfg_we,
// i_cfg_idx and i_cfg_data: index 0 sequence length, index 1 threshold.
`include "pair_cooccurrence_threshold_assert.svh"
module pair_cooccurrence_threshold #(
    parameter int MAX_LENGTH  = pct_pkg::DEF_MAX_LENGTH,
    parameter int ALPHABET    = pct_pkg::DEF_ALPHABET,
    parameter int COUNT_WIDTH = pct_pkg::DEF_COUNT_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pct_pkg::t_item                 i_item,
    output logic                           o_result_valid,
    output pct_pkg::t_result               o_result,
    input  logic                           i_cfg_we,
    input  logic [pct_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pct_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NPP   = (MAX_LENGTH * (MAX_LENGTH - 1)) / 2;
    localparam int DEPTH = NPP * ALPHABET * ALPHABET;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $bits(pct_pkg::t_task) + AW;

    logic [pct_pkg::SEQ_W-1:0] r_seq_len;
    logic [pct_pkg::THR_W-1:0] r_threshold;

    logic             w_accept;
    logic             w_hold;
    logic             w_sweeping;
    logic             w_push;
    logic             w_pop;
    pct_pkg::t_task   w_task;
    logic [AW-1:0]    w_addr;
    pct_pkg::t_task   w_q_task;
    logic [AW-1:0]    w_q_addr;
    pct_pkg::t_q_stat w_q_stat;

    assign busy     = w_sweeping || w_hold;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len   <= pct_pkg::RESET_SEQ_LEN;
            r_threshold <= pct_pkg::RESET_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pct_pkg::CFG_SEQ_LEN: begin
                    r_seq_len <= i_cfg_data[pct_pkg::SEQ_W-1:0];
                end
                pct_pkg::CFG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[pct_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    pct_front #(
        .MAX_LENGTH (MAX_LENGTH),
        .ALPHABET   (ALPHABET),
        .AW         (AW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_item    (i_item),
        .i_seq_len (r_seq_len),
        .i_q_full  (w_q_stat.full),
        .o_push    (w_push),
        .o_task    (w_task),
        .o_addr    (w_addr),
        .o_hold    (w_hold)
    );

    pct_fifo #(
        .WIDTH (TW),
        .DEPTH (pct_pkg::Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_task, w_addr}),
        .i_pop   (w_pop),
        .o_data  ({w_q_task, w_q_addr}),
        .o_stat  (w_q_stat)
    );

    pct_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .DEPTH       (DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_task         (w_q_task),
        .i_addr         (w_q_addr),
        .i_q_stat       (w_q_stat),
        .o_pop          (w_pop),
        .i_threshold    (r_threshold),
        .o_result       (o_result),
        .o_result_valid (o_result_valid),
        .o_sweeping     (w_sweeping)
    );

    `PCT_ASSERT_SAME(a_sweep_busy, i_clk, i_rst_n, w_sweeping, busy, "port open in sweep")
    `PCT_ASSERT_SAME(a_reset_sweep, i_clk, i_rst_n, !$past(i_rst_n), w_sweeping && busy, "no sweep")
    `PCT_ASSERT_SAME(a_queue_room, i_clk, i_rst_n, w_push, !w_q_stat.full, "task queue overflow")

endmodule

>>> sv/pct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> sv/pct_fifo.sv
// Short flop-based queue between the front end and the count engine.
// Depends on pct_pkg for the status struct.
module pct_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = pct_pkg::Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output pct_pkg::t_q_stat o_stat
);

    localparam int PTRW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTRW-1:0]  r_wr;
    logic [PTRW-1:0]  r_rd;
    logic [PTRW:0]    r_cnt;
    logic [PTRW-1:0]  n_wr;
    logic [PTRW-1:0]  n_rd;
    logic [PTRW:0]    n_cnt;

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (PTRW+1)'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTRW'(DEPTH - 1)) ? '0 : r_wr + PTRW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTRW'(DEPTH - 1)) ? '0 : r_rd + PTRW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (PTRW+1)'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - (PTRW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> sv/pct_front.sv
// Front end: takes items, buffers letters, walks position pairs of a finished
// sequence, queues a count-store task per pair or clear. Depends on pct_pkg.
module pct_front #(
    parameter int MAX_LENGTH = pct_pkg::DEF_MAX_LENGTH,
    parameter int ALPHABET   = pct_pkg::DEF_ALPHABET,
    parameter int AW         = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  pct_pkg::t_item            i_item,
    input  logic [pct_pkg::SEQ_W-1:0] i_seq_len,
    input  logic                      i_q_full,
    output logic                      o_push,
    output pct_pkg::t_task            o_task,
    output logic [AW-1:0]             o_addr,
    output logic                      o_hold
);

    localparam int LW   = pct_pkg::LETTER_W;
    localparam int PSW  = pct_pkg::POS_W;
    localparam int PW   = $clog2(MAX_LENGTH);
    localparam int NPP  = (MAX_LENGTH * (MAX_LENGTH - 1)) / 2;
    localparam int PIW  = (NPP > 1) ? $clog2(NPP) : 1;

    // Reduce a letter into the alphabet by conditional subtracts.
    function automatic logic [LW-1:0] f_mod(input logic [LW-1:0] v);
        logic [LW:0] r;
        r = {1'b0, v};
        for (int k = LW - 1; k >= 0; k--) begin
            if (int'(r) >= (ALPHABET << k)) begin
                r = r - (LW+1)'(ALPHABET << k);
            end
        end
        return r[LW-1:0];
    endfunction

    logic [PSW-1:0] r_pos;
    logic           r_walk;
    logic           r_clear_pend;
    logic [LW-1:0]  r_buf [MAX_LENGTH];
    logic [LW-1:0]  r_q   [MAX_LENGTH];
    logic [LW-1:0]  r_r   [MAX_LENGTH];
    logic [PSW-1:0] r_p1;
    logic [PSW-1:0] r_p2;
    logic [PIW-1:0] r_pidx;
    logic [PSW-1:0] r_wlen;

    logic [PSW-1:0] n_pos;
    logic           n_walk;
    logic           n_clear_pend;
    logic [LW-1:0]  n_q   [MAX_LENGTH];
    logic [LW-1:0]  n_r   [MAX_LENGTH];
    logic [PSW-1:0] n_p1;
    logic [PSW-1:0] n_p2;
    logic [PIW-1:0] n_pidx;
    logic [PSW-1:0] n_wlen;

    logic [PSW-1:0] w_len;
    logic           w_pos_last;
    logic [LW-1:0]  w_letter;
    logic           w_is_letter;
    logic           w_step;
    logic           w_p1_end;
    logic           w_p2_end;
    logic [LW-1:0]  w_ld [MAX_LENGTH+2];
    logic [LW-1:0]  w_qx [MAX_LENGTH+2];
    logic [LW-1:0]  w_rx [MAX_LENGTH+2];

    always_comb begin
        if (i_seq_len < pct_pkg::SEQ_W'(2)) begin
            w_len = PSW'(2);
        end else if (int'(i_seq_len) > MAX_LENGTH) begin
            w_len = PSW'(MAX_LENGTH);
        end else begin
            w_len = i_seq_len;
        end
    end

    assign w_pos_last  = ({1'b0, r_pos} + (PSW+1)'(1)) >= {1'b0, w_len};
    assign w_letter    = f_mod(i_item.letter);
    assign w_is_letter = i_accept && (i_item.command == pct_pkg::CMD_LETTER);
    assign o_hold      = r_clear_pend || (r_walk && w_pos_last);

    assign w_p1_end = (r_p1 == r_wlen - PSW'(2));
    assign w_p2_end = (r_p2 == r_wlen - PSW'(1));
    assign w_step   = r_walk && !i_q_full;
    assign o_push   = !i_q_full && (r_walk || r_clear_pend);

    always_comb begin
        for (int i = 0; i < MAX_LENGTH; i++) begin
            w_ld[i] = (int'(r_pos) == i) ? w_letter : r_buf[i];
            w_qx[i] = r_q[i];
            w_rx[i] = r_r[i];
        end
        for (int i = MAX_LENGTH; i < MAX_LENGTH + 2; i++) begin
            w_ld[i] = '0;
            w_qx[i] = '0;
            w_rx[i] = '0;
        end
    end

    always_comb begin
        if (r_walk) begin
            o_task.is_clear        = 1'b0;
            o_task.last            = w_p1_end && w_p2_end;
            o_task.first_letter    = r_q[0];
            o_task.first_position  = r_p1;
            o_task.second_letter   = r_r[0];
            o_task.second_position = r_p2;
            o_addr = AW'(r_pidx) * AW'(ALPHABET * ALPHABET)
                   + AW'(r_q[0]) * AW'(ALPHABET) + AW'(r_r[0]);
        end else begin
            o_task          = '0;
            o_task.is_clear = 1'b1;
            o_addr          = '0;
        end
    end

    always_comb begin
        n_pos        = r_pos;
        n_walk       = r_walk;
        n_clear_pend = r_clear_pend;
        n_p1         = r_p1;
        n_p2         = r_p2;
        n_pidx       = r_pidx;
        n_wlen       = r_wlen;
        for (int i = 0; i < MAX_LENGTH; i++) begin
            n_q[i] = r_q[i];
            n_r[i] = r_r[i];
        end

        if (i_accept && (i_item.command == pct_pkg::CMD_CLEAR)) begin
            n_clear_pend = 1'b1;
        end else if (w_is_letter) begin
            if (w_pos_last) begin
                n_pos  = '0;
                n_walk = 1'b1;
                n_p1   = '0;
                n_p2   = PSW'(1);
                n_pidx = '0;
                n_wlen = w_len;
                for (int i = 0; i < MAX_LENGTH; i++) begin
                    n_q[i] = w_ld[i];
                    n_r[i] = w_ld[i+1];
                end
            end else begin
                n_pos = r_pos + PSW'(1);
            end
        end

        if (w_step) begin
            n_pidx = r_pidx + PIW'(1);
            if (w_p2_end) begin
                if (w_p1_end) begin
                    n_walk = 1'b0;
                end else begin
                    n_p1 = r_p1 + PSW'(1);
                    n_p2 = r_p1 + PSW'(2);
                    for (int i = 0; i < MAX_LENGTH; i++) begin
                        n_q[i] = w_qx[i+1];
                        n_r[i] = w_qx[i+2];
                    end
                end
            end else begin
                n_p2 = r_p2 + PSW'(1);
                for (int i = 0; i < MAX_LENGTH; i++) begin
                    n_r[i] = w_rx[i+1];
                end
            end
        end

        if (o_push && !r_walk) begin
            n_clear_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_walk       <= 1'b0;
            r_clear_pend <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_walk       <= n_walk;
            r_clear_pend <= n_clear_pend;
        end
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_pidx <= n_pidx;
        r_wlen <= n_wlen;
        for (int i = 0; i < MAX_LENGTH; i++) begin
            r_q[i] <= n_q[i];
            r_r[i] <= n_r[i];
        end
        if (w_is_letter && (int'(r_pos) < MAX_LENGTH)) begin
            r_buf[r_pos[PW-1:0]] <= w_letter;
        end
    end

endmodule

>>> sv/pct_back.sv
// Count engine: read-modify-write of the pair count store, threshold match,
// pair numbering, last-of-run marking and the clearing sweep.
// Depends on pct_pkg and pct_ram.
module pct_back #(
    parameter int COUNT_WIDTH = pct_pkg::DEF_COUNT_WIDTH,
    parameter int DEPTH       = 36864
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pct_pkg::t_task            i_task,
    input  logic [$clog2(DEPTH)-1:0]  i_addr,
    input  pct_pkg::t_q_stat          i_q_stat,
    output logic                      o_pop,
    input  logic [pct_pkg::THR_W-1:0] i_threshold,
    output pct_pkg::t_result          o_result,
    output logic                      o_result_valid,
    output logic                      o_sweeping
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = COUNT_WIDTH;
    localparam int CMPW = (CW > pct_pkg::THR_W) ? CW : pct_pkg::THR_W;

    typedef enum logic {
        S_SWEEP,
        S_RUN
    } t_state;

    t_state                    r_state;
    logic [AW-1:0]             r_sw_addr;
    logic                      r_s_valid;
    pct_pkg::t_task            r_s_task;
    logic [AW-1:0]             r_s_addr;
    logic                      r_w_valid;
    logic [AW-1:0]             r_w_addr;
    logic [CW-1:0]             r_w_data;
    logic                      r_pend_valid;
    pct_pkg::t_result          r_pend;
    logic                      r_flush;
    logic [pct_pkg::NUM_W-1:0] r_found;

    logic [CW-1:0]    w_rdata;
    logic [CW-1:0]    w_cur;
    logic [CW-1:0]    w_inc;
    logic             w_upd;
    logic             w_hit;
    logic             w_emit;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [CW-1:0]    w_wdata;
    pct_pkg::t_result w_new;
    pct_pkg::t_result w_out;

    assign o_sweeping = (r_state == S_SWEEP);
    assign o_pop      = (r_state == S_RUN) && !i_q_stat.empty;

    // Forward the write made in the same cycle as this entry's read.
    assign w_cur  = (r_w_valid && (r_w_addr == r_s_addr)) ? r_w_data : w_rdata;
    assign w_inc  = w_cur + CW'(1);
    assign w_upd  = r_s_valid && !(&w_cur);
    assign w_hit  = w_upd && (CMPW'(w_inc) == CMPW'(i_threshold));
    assign w_emit = r_pend_valid && (w_hit || r_flush);

    assign w_we    = o_sweeping || w_upd;
    assign w_waddr = o_sweeping ? r_sw_addr : r_s_addr;
    assign w_wdata = o_sweeping ? '0 : w_inc;

    always_comb begin
        w_new.first_letter    = r_s_task.first_letter;
        w_new.first_position  = r_s_task.first_position;
        w_new.second_letter   = r_s_task.second_letter;
        w_new.second_position = r_s_task.second_position;
        w_new.pair_number     = r_found;
        w_new.last_of_run     = 1'b0;
        w_out                 = r_pend;
        w_out.last_of_run     = r_flush;
    end

    pct_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (i_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_SWEEP;
            r_sw_addr      <= '0;
            r_s_valid      <= 1'b0;
            r_w_valid      <= 1'b0;
            r_pend_valid   <= 1'b0;
            r_flush        <= 1'b0;
            r_found        <= '0;
            o_result_valid <= 1'b0;
        end else begin
            r_s_valid      <= o_pop && !i_task.is_clear;
            r_w_valid      <= w_upd;
            r_flush        <= r_s_valid && r_s_task.last;
            o_result_valid <= w_emit;
            if (w_hit) begin
                r_pend_valid <= 1'b1;
            end else if (r_flush) begin
                r_pend_valid <= 1'b0;
            end
            if (o_pop && i_task.is_clear) begin
                r_found <= '0;
            end else if (w_hit && (r_found != pct_pkg::NUM_MAX)) begin
                r_found <= r_found + pct_pkg::NUM_W'(1);
            end
            case (r_state)
                S_SWEEP: begin
                    r_sw_addr <= r_sw_addr + AW'(1);
                    if (r_sw_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (o_pop && i_task.is_clear) begin
                        r_state   <= S_SWEEP;
                        r_sw_addr <= '0;
                    end
                end
                default: begin
                    r_state <= S_SWEEP;
                end
            endcase
        end
        r_s_task <= i_task;
        r_s_addr <= i_addr;
        r_w_addr <= r_s_addr;
        r_w_data <= w_inc;
        if (w_hit) begin
            r_pend <= w_new;
        end
        o_result <= w_out;
    end

endmodule

>>> sim/tb_pair_cooccurrence_threshold.sv
// Self-checking testbench for pair_cooccurrence_threshold: streams letters and clears,
// predicts every reported pair and compares it with o_result. Register settings change between phases.
// Depends on pct_pkg and the pair_cooccurrence_threshold RTL.
module tb_pair_cooccurrence_threshold;
    import pct_pkg::*;

    localparam int MAX_LEN       = DEF_MAX_LENGTH;
    localparam int ALPH          = DEF_ALPHABET;
    localparam int COUNT_W       = DEF_COUNT_WIDTH;
    localparam int NUM_SLOTS     = (MAX_LEN * (MAX_LEN - 1) / 2) * ALPH * ALPH;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 200000;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 30;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_item                 i_item = '0;
    logic                  o_result_valid;
    t_result               o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pair_cooccurrence_threshold dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Predictor state
    logic [SEQ_W-1:0]    seq_len_cfg = RESET_SEQ_LEN;
    logic [THR_W-1:0]    thr_cfg = RESET_THRESHOLD;
    logic [LETTER_W-1:0] seq_letters [MAX_LEN];
    int                  fill_pos = 0;
    logic [COUNT_W-1:0]  pair_tally [NUM_SLOTS];
    logic [NUM_W-1:0]    pair_serial = '0;

    t_item   letter_stream_q [$];
    t_result reported_pairs_q [$];

    int items_taken = 0;
    int letters_seen = 0;
    int clears_seen = 0;
    int walks_done = 0;
    int pairs_checked = 0;
    int settings_used = 0;
    int mismatch_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_cycles = 0;

    int phase_len [NUM_PHASES] = '{9, 15, 0, 5, 3, 2, 7, 1, 4, 9, 12, 8};
    int phase_thr [NUM_PHASES] = '{1, 2, 3, 1, 2, 0, 2, 65535, 1, 3, 1, 2};

    initial begin
        foreach (pair_tally[k]) begin
            pair_tally[k] = '0;
        end
        foreach (seq_letters[k]) begin
            seq_letters[k] = '0;
        end
    end

    // Update the model with one accepted item and queue the pairs it reports.
    task automatic absorb_item(input t_item it);
        int      len;
        int      pos1;
        int      pos2;
        int      pair_idx;
        int      slot;
        int      hits;
        t_result r;
        if (it.command == CMD_CLEAR) begin
            foreach (pair_tally[k]) begin
                pair_tally[k] = '0;
            end
            pair_serial = '0;
            clears_seen++;
            return;
        end
        letters_seen++;
        len = (seq_len_cfg < 2) ? 2 : (seq_len_cfg > MAX_LEN) ? MAX_LEN : int'(seq_len_cfg);
        if (fill_pos < MAX_LEN) begin
            seq_letters[fill_pos] = it.letter;
        end
        if (fill_pos + 1 < len) begin
            fill_pos++;
            return;
        end
        fill_pos = 0;
        walks_done++;
        pair_idx = 0;
        hits = 0;
        for (pos1 = 0; pos1 + 1 < len; pos1++) begin
            for (pos2 = pos1 + 1; pos2 < len; pos2++) begin
                slot = (pair_idx * ALPH + int'(seq_letters[pos1])) * ALPH
                       + int'(seq_letters[pos2]);
                pair_idx++;
                if (pair_tally[slot] != '1) begin
                    pair_tally[slot] = pair_tally[slot] + COUNT_W'(1);
                    if (pair_tally[slot] == thr_cfg) begin
                        r.first_letter    = seq_letters[pos1];
                        r.first_position  = POS_W'(pos1);
                        r.second_letter   = seq_letters[pos2];
                        r.second_position = POS_W'(pos2);
                        r.pair_number     = pair_serial;
                        r.last_of_run     = 1'b0;
                        reported_pairs_q = {reported_pairs_q, r};
                        hits++;
                        if (pair_serial != NUM_MAX) begin
                            pair_serial = pair_serial + NUM_W'(1);
                        end
                    end
                end
            end
        end
        if (hits > 0) begin
            r = reported_pairs_q[reported_pairs_q.size() - 1];
            r.last_of_run = 1'b1;
            reported_pairs_q[reported_pairs_q.size() - 1] = r;
        end
    endtask

    // Driver: bursts of items with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) begin
                absorb_item(i_item);
                items_taken++;
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (letter_stream_q.size() > 0) begin
                i_item <= letter_stream_q.pop_front();
                start <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    if ($urandom_range(0, 3) == 0) begin
                        gap_left = 0;
                    end else if ($urandom_range(0, 4) == 0) begin
                        gap_left = $urandom_range(1, 40);
                    end else begin
                        gap_left = $urandom_range(1, 6);
                    end
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    function automatic void check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // Monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_result_valid) begin
            if (reported_pairs_q.size() == 0) begin
                $display("%0t: unexpected pair, expected none, actual %p", $time, o_result);
                mismatch_count++;
            end else begin
                want = reported_pairs_q.pop_front();
                check_field("first_letter", want.first_letter, o_result.first_letter);
                check_field("first_position", want.first_position, o_result.first_position);
                check_field("second_letter", want.second_letter, o_result.second_letter);
                check_field("second_position", want.second_position,
                            o_result.second_position);
                check_field("pair_number", want.pair_number, o_result.pair_number);
                check_field("last_of_run", want.last_of_run, o_result.last_of_run);
                pairs_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_result_valid) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, no progress for %0d cycles", $time, stall_cycles);
                $display("FAIL pair_cooccurrence_threshold");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic push_letter(input int letter);
        t_item it;
        it.command = CMD_LETTER;
        it.letter  = LETTER_W'(letter);
        letter_stream_q = {letter_stream_q, it};
    endtask

    task automatic push_clear();
        t_item it;
        it.command = CMD_CLEAR;
        it.letter  = LETTER_W'($urandom_range(0, 31));
        letter_stream_q = {letter_stream_q, it};
    endtask

    // Hold the sender until all items are taken, every pair has come and the walk is over.
    task automatic drain_and_settle();
        while (letter_stream_q.size() != 0 || start) begin
            @(negedge i_clk);
        end
        while (reported_pairs_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        while (busy) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_registers(input logic [SEQ_W-1:0] len, input logic [THR_W-1:0] thr);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SEQ_LEN;
        i_cfg_data <= CFG_DATA_W'(len);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_THRESHOLD;
        i_cfg_data <= CFG_DATA_W'(thr);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        seq_len_cfg = len;
        thr_cfg     = thr;
        settings_used++;
    endtask

    task automatic queue_phase(input int n, input int pool_pct);
        t_item               it;
        logic [LETTER_W-1:0] pool_a;
        logic [LETTER_W-1:0] pool_b;
        pool_a = LETTER_W'($urandom_range(0, 31));
        pool_b = LETTER_W'($urandom_range(0, 31));
        repeat (n) begin
            it.command = ($urandom_range(0, 99) == 0) ? CMD_CLEAR : CMD_LETTER;
            if ($urandom_range(1, 100) <= pool_pct) begin
                it.letter = $urandom_range(0, 1) ? pool_a : pool_b;
            end else begin
                it.letter = LETTER_W'($urandom_range(0, 31));
            end
            letter_stream_q = {letter_stream_q, it};
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full sequence at reset settings writes every buffer entry
        push_letter(31);
        push_letter(0);
        push_letter(21);
        push_letter(10);
        push_letter(31);
        push_letter(0);
        push_letter(1);
        push_letter(30);
        push_letter(16);
        push_clear();
        drain_and_settle();

        // Shortest sequence, report on the second hit
        program_registers(4'd2, 16'd2);
        push_letter(31);
        push_letter(31);
        push_letter(31);
        push_letter(31);
        push_letter(0);
        push_letter(31);
        drain_and_settle();

        // Length below range acts as two
        program_registers(4'd0, 16'd1);
        push_letter(5);
        push_letter(6);
        drain_and_settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            program_registers(SEQ_W'(phase_len[p]), THR_W'(phase_thr[p]));
            queue_phase(PHASE_ITEMS, (phase_thr[p] == 1) ? 25 : 85);
            drain_and_settle();
        end

        $display("Run covered %0d items (%0d letters, %0d clears) over %0d register settings;",
                 items_taken, letters_seen, clears_seen, settings_used);
        $display("%0d sequence walks, %0d reported pairs checked, %0d mismatches.",
                 walks_done, pairs_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS pair_cooccurrence_threshold");
        end else begin
            $display("FAIL pair_cooccurrence_threshold");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/pct_pkg.sv
sv/pct_ram.sv
sv/pct_fifo.sv
sv/pct_front.sv
sv/pct_back.sv
sv/pair_cooccurrence_threshold.sv
sim/tb_pair_cooccurrence_threshold.sv
